// ===== rtl/core/olr_pkg.sv =====
// Shared constants, types and the screen mapping function of the line rasteriser.
package olr_pkg;

   localparam int COORD_BITS = 12;
   localparam int WALK_BITS  = COORD_BITS + 1;
   localparam int DEC_BITS   = COORD_BITS + 3;

   typedef enum logic {
      FUNC_START   = 1'b0,
      FUNC_ADVANCE = 1'b1
   } func_type;

   // Zone numbering follows the octant code seen downstream.
   typedef enum logic [2:0] {
      ZONE_E_NE = 3'd0,
      ZONE_NE_N = 3'd1,
      ZONE_N_NW = 3'd2,
      ZONE_NW_W = 3'd3,
      ZONE_W_SW = 3'd4,
      ZONE_SW_S = 3'd5,
      ZONE_S_SE = 3'd6,
      ZONE_SE_E = 3'd7
   } zone_type;

   typedef struct packed {
      zone_type                     zone;
      logic signed [WALK_BITS-1:0]  walk_x;
      logic signed [WALK_BITS-1:0]  walk_y;
      logic signed [WALK_BITS-1:0]  stop_x;
      logic signed [DEC_BITS-1:0]   decision;
      logic signed [DEC_BITS-1:0]   step_east;
      logic signed [DEC_BITS-1:0]   step_diagonal;
   } line_setup_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
   } point_type;

   typedef struct packed {
      logic                         pixel_valid;
      logic signed [COORD_BITS-1:0] pixel_x;
      logic signed [COORD_BITS-1:0] pixel_y;
      logic [2:0]                   octant;
      logic                         last;
   } pixel_type;

   // Maps a first-octant position back to screen coordinates for the given zone.
   function automatic point_type map_to_screen(zone_type zone,
                                               logic signed [WALK_BITS-1:0] x,
                                               logic signed [WALK_BITS-1:0] y);
      logic signed [WALK_BITS-1:0] nx;
      logic signed [WALK_BITS-1:0] ny;
      logic signed [WALK_BITS-1:0] sx;
      logic signed [WALK_BITS-1:0] sy;
      point_type                   p;
      nx = -x;
      ny = -y;
      unique case (zone)
         ZONE_E_NE: begin sx = x;  sy = y;  end
         ZONE_NE_N: begin sx = y;  sy = x;  end
         ZONE_N_NW: begin sx = ny; sy = x;  end
         ZONE_NW_W: begin sx = nx; sy = y;  end
         ZONE_W_SW: begin sx = nx; sy = ny; end
         ZONE_SW_S: begin sx = ny; sy = nx; end
         ZONE_S_SE: begin sx = y;  sy = nx; end
         ZONE_SE_E: begin sx = x;  sy = ny; end
      endcase
      p.x = sx[COORD_BITS-1:0];
      p.y = sy[COORD_BITS-1:0];
      return p;
   endfunction

endpackage

// ===== rtl/core/olr_zone_map.sv =====
// Classifies a line into its zone and folds it into the first octant.
module olr_zone_map
   import olr_pkg::*;
(
   input  logic signed [COORD_BITS-1:0] start_x,
   input  logic signed [COORD_BITS-1:0] start_y,
   input  logic signed [COORD_BITS-1:0] end_x,
   input  logic signed [COORD_BITS-1:0] end_y,
   output line_setup_type               setup
);

   logic signed [WALK_BITS-1:0] ex0, ey0, ex1, ey1;
   logic signed [WALK_BITS-1:0] nx0, ny0, nx1, ny1;
   logic signed [WALK_BITS-1:0] dx, dy, neg_dx, neg_dy;
   logic [COORD_BITS-1:0]       adx, ady, major, minor;
   logic signed [DEC_BITS-1:0]  major_d, minor_d;
   logic                        steep;

   always_comb begin
      ex0 = WALK_BITS'(start_x);
      ey0 = WALK_BITS'(start_y);
      ex1 = WALK_BITS'(end_x);
      ey1 = WALK_BITS'(end_y);
      nx0 = -ex0;
      ny0 = -ey0;
      nx1 = -ex1;
      ny1 = -ey1;
      dx = ex1 - ex0;
      dy = ey1 - ey0;
      neg_dx = -dx;
      neg_dy = -dy;
      adx = dx[WALK_BITS-1] ? neg_dx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
      ady = dy[WALK_BITS-1] ? neg_dy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
      steep = ady > adx;

      unique case ({steep, dx[WALK_BITS-1], dy[WALK_BITS-1]})
         3'b000: begin
            setup.zone = ZONE_E_NE; setup.walk_x = ex0; setup.walk_y = ey0; setup.stop_x = ex1;
         end
         3'b010: begin
            setup.zone = ZONE_NW_W; setup.walk_x = nx0; setup.walk_y = ey0; setup.stop_x = nx1;
         end
         3'b011: begin
            setup.zone = ZONE_W_SW; setup.walk_x = nx0; setup.walk_y = ny0; setup.stop_x = nx1;
         end
         3'b001: begin
            setup.zone = ZONE_SE_E; setup.walk_x = ex0; setup.walk_y = ny0; setup.stop_x = ex1;
         end
         3'b100: begin
            setup.zone = ZONE_NE_N; setup.walk_x = ey0; setup.walk_y = ex0; setup.stop_x = ey1;
         end
         3'b110: begin
            setup.zone = ZONE_N_NW; setup.walk_x = ey0; setup.walk_y = nx0; setup.stop_x = ey1;
         end
         3'b111: begin
            setup.zone = ZONE_SW_S; setup.walk_x = ny0; setup.walk_y = nx0; setup.stop_x = ny1;
         end
         3'b101: begin
            setup.zone = ZONE_S_SE; setup.walk_x = ny0; setup.walk_y = ex0; setup.stop_x = ny1;
         end
      endcase

      // After folding, the major axis runs along x and the minor step is never negative.
      major = steep ? ady : adx;
      minor = steep ? adx : ady;
      major_d = {3'b000, major};
      minor_d = {3'b000, minor};
      setup.step_east     = minor_d <<< 1;
      setup.step_diagonal = (minor_d - major_d) <<< 1;
      setup.decision      = (minor_d <<< 1) - major_d;
   end

endmodule

// ===== rtl/core/olr_walker.sv =====
// Line walk state and the decision step that produces one pixel per word.
module olr_walker
   import olr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           take,
   input  func_type       func,
   input  line_setup_type setup,
   output pixel_type      result
);

   logic                        line_active_ff, line_active_in;
   zone_type                    zone_ff, zone_in;
   logic signed [WALK_BITS-1:0] walk_x_ff, walk_x_in;
   logic signed [WALK_BITS-1:0] walk_y_ff, walk_y_in;
   logic signed [WALK_BITS-1:0] stop_x_ff, stop_x_in;
   logic signed [DEC_BITS-1:0]  decision_ff, decision_in;
   logic signed [DEC_BITS-1:0]  step_east_ff, step_east_in;
   logic signed [DEC_BITS-1:0]  step_diagonal_ff, step_diagonal_in;
   point_type                   screen;

   always_comb begin
      line_active_in   = line_active_ff;
      zone_in          = zone_ff;
      walk_x_in        = walk_x_ff;
      walk_y_in        = walk_y_ff;
      stop_x_in        = stop_x_ff;
      decision_in      = decision_ff;
      step_east_in     = step_east_ff;
      step_diagonal_in = step_diagonal_ff;

      if (func == FUNC_START) begin
         zone_in          = setup.zone;
         walk_x_in        = setup.walk_x;
         walk_y_in        = setup.walk_y;
         stop_x_in        = setup.stop_x;
         decision_in      = setup.decision;
         step_east_in     = setup.step_east;
         step_diagonal_in = setup.step_diagonal;
         line_active_in   = setup.walk_x != setup.stop_x;
      end else if (line_active_ff) begin
         if (decision_ff[DEC_BITS-1]) begin
            decision_in = decision_ff + step_east_ff;
         end else begin
            decision_in = decision_ff + step_diagonal_ff;
            walk_y_in   = walk_y_ff + WALK_BITS'(1);
         end
         walk_x_in      = walk_x_ff + WALK_BITS'(1);
         line_active_in = walk_x_in != stop_x_ff;
      end

      screen = map_to_screen(zone_in, walk_x_in, walk_y_in);

      // An advance with no line in progress gives an empty word.
      if (func == FUNC_START || line_active_ff) begin
         result.pixel_valid = 1'b1;
         result.pixel_x     = screen.x;
         result.pixel_y     = screen.y;
         result.octant      = zone_in;
         result.last        = ~line_active_in;
      end else begin
         result = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_active_ff   <= 1'b0;
         zone_ff          <= ZONE_E_NE;
         walk_x_ff        <= '0;
         walk_y_ff        <= '0;
         stop_x_ff        <= '0;
         decision_ff      <= '0;
         step_east_ff     <= '0;
         step_diagonal_ff <= '0;
      end else if (take) begin
         line_active_ff   <= line_active_in;
         zone_ff          <= zone_in;
         walk_x_ff        <= walk_x_in;
         walk_y_ff        <= walk_y_in;
         stop_x_ff        <= stop_x_in;
         decision_ff      <= decision_in;
         step_east_ff     <= step_east_in;
         step_diagonal_ff <= step_diagonal_in;
      end
   end

endmodule

// ===== rtl/core/octant_line_rasterizer.sv =====
// Eight-zone midpoint line rasteriser: input register, walker and result register.
//
// The request channel takes one word per cycle while req_stall is low. A start
// word (func 0) carries both endpoints and yields the start pixel; each advance
// word (func 1) yields the next pixel of the current line. The pixel that reaches
// the endpoint has last set, and a zero-length line gives a single pixel with last
// set. An advance with no line in progress yields a word with pixel_valid low and
// all other fields zero. A start word drops any line still in progress.
//
// Every request word gives exactly one response word. The word is held in the input
// register and is then written to the result register, from which its response
// appears on the response channel. While rsp_stall is low, sustained throughput
// is one word per cycle; the walk step is one add and one compare
// between the input register and the result register.
//
// When rsp_stall is high the result register holds its word and the input register
// holds the next one, so req_stall rises only while both are full. A synchronous
// reset empties both registers and clears the line state.
module octant_line_rasterizer
   import olr_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_func,
   input  logic signed [COORD_BITS-1:0] req_start_x,
   input  logic signed [COORD_BITS-1:0] req_start_y,
   input  logic signed [COORD_BITS-1:0] req_end_x,
   input  logic signed [COORD_BITS-1:0] req_end_y,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_pixel_valid,
   output logic signed [COORD_BITS-1:0] rsp_pixel_x,
   output logic signed [COORD_BITS-1:0] rsp_pixel_y,
   output logic [2:0]                   rsp_octant,
   output logic                         rsp_last
);

   logic                         in_valid_ff, in_valid_in;
   func_type                     func_ff;
   logic signed [COORD_BITS-1:0] start_x_ff, start_y_ff, end_x_ff, end_y_ff;
   logic                         out_valid_ff, out_valid_in;
   pixel_type                    result_ff, result_in;
   line_setup_type               setup;
   logic                         req_accept, move, take;

   assign move         = ~out_valid_ff | ~rsp_stall;
   assign take         = in_valid_ff & move;
   assign req_stall    = in_valid_ff & ~move;
   assign req_accept   = req_valid & ~req_stall;
   assign in_valid_in  = req_accept | (in_valid_ff & ~move);
   assign out_valid_in = take | (out_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         func_ff    <= func_type'(req_func);
         start_x_ff <= req_start_x;
         start_y_ff <= req_start_y;
         end_x_ff   <= req_end_x;
         end_y_ff   <= req_end_y;
      end
      if (take) begin
         result_ff <= result_in;
      end
   end

   olr_zone_map u_zone_map (
      .start_x (start_x_ff),
      .start_y (start_y_ff),
      .end_x   (end_x_ff),
      .end_y   (end_y_ff),
      .setup   (setup)
   );

   olr_walker u_walker (
      .clock  (clock),
      .reset  (reset),
      .take   (take),
      .func   (func_ff),
      .setup  (setup),
      .result (result_in)
   );

   assign rsp_valid       = out_valid_ff;
   assign rsp_pixel_valid = result_ff.pixel_valid;
   assign rsp_pixel_x     = result_ff.pixel_x;
   assign rsp_pixel_y     = result_ff.pixel_y;
   assign rsp_octant      = result_ff.octant;
   assign rsp_last        = result_ff.last;

endmodule

// ===== test/tb_octant_line_rasterizer.sv =====
// Self-checking testbench for the eight-zone midpoint line rasteriser.
module tb_octant_line_rasterizer;
   import olr_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int PHASE_WORDS   = 550;
   localparam int BACKLOG_HOLD  = 100;
   localparam int REPORT_LIMIT  = 100;

   typedef struct packed {
      func_type                     func;
      logic signed [COORD_BITS-1:0] x0;
      logic signed [COORD_BITS-1:0] y0;
      logic signed [COORD_BITS-1:0] x1;
      logic signed [COORD_BITS-1:0] y1;
   } pixel_req_type;

   typedef struct {
      pixel_req_type word;
      bit            typed;
      pixel_type     want;
   } directed_row_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic                         req_func = 1'b0;
   logic signed [COORD_BITS-1:0] req_start_x = '0;
   logic signed [COORD_BITS-1:0] req_start_y = '0;
   logic signed [COORD_BITS-1:0] req_end_x = '0;
   logic signed [COORD_BITS-1:0] req_end_y = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic                         rsp_pixel_valid;
   logic signed [COORD_BITS-1:0] rsp_pixel_x;
   logic signed [COORD_BITS-1:0] rsp_pixel_y;
   logic [2:0]                   rsp_octant;
   logic                         rsp_last;

   // Line walker state as the block should hold it.
   logic                         walk_active = 1'b0;
   zone_type                     walk_zone = ZONE_E_NE;
   logic signed [WALK_BITS-1:0]  walk_x = '0;
   logic signed [WALK_BITS-1:0]  walk_y = '0;
   logic signed [WALK_BITS-1:0]  stop_x = '0;
   logic signed [DEC_BITS-1:0]   decision = '0;
   logic signed [DEC_BITS-1:0]   step_east = '0;
   logic signed [DEC_BITS-1:0]   step_diag = '0;

   pixel_type        pending_pixels[$];
   directed_row_type directed_rows[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int backlog_ask = 0;
   int backlog_seen = 0;
   int backlog_left = 0;
   int words_sent = 0;
   int lines_started = 0;
   int idle_advances = 0;
   int pixels_checked = 0;
   int held_off_cycles = 0;
   int fault_count = 0;
   int cycle_count = 0;

   octant_line_rasterizer u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_start_x     (req_start_x),
      .req_start_y     (req_start_y),
      .req_end_x       (req_end_x),
      .req_end_y       (req_end_y),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_valid (rsp_pixel_valid),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_octant      (rsp_octant),
      .rsp_last        (rsp_last)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Pixel at the current walk position, folded back from the first octant.
   function automatic pixel_type screen_pixel(bit at_end);
      int        wx;
      int        wy;
      int        sx;
      int        sy;
      pixel_type p;
      wx = walk_x;
      wy = walk_y;
      case (walk_zone)
         ZONE_E_NE: begin sx = wx;  sy = wy;  end
         ZONE_NE_N: begin sx = wy;  sy = wx;  end
         ZONE_N_NW: begin sx = -wy; sy = wx;  end
         ZONE_NW_W: begin sx = -wx; sy = wy;  end
         ZONE_W_SW: begin sx = -wx; sy = -wy; end
         ZONE_SW_S: begin sx = -wy; sy = -wx; end
         ZONE_S_SE: begin sx = wy;  sy = -wx; end
         default:   begin sx = wx;  sy = -wy; end
      endcase
      p.pixel_valid = 1'b1;
      p.pixel_x     = COORD_BITS'(sx);
      p.pixel_y     = COORD_BITS'(sy);
      p.octant      = walk_zone;
      p.last        = at_end;
      return p;
   endfunction

   // Applies one request word to the walker state and returns the pixel word it gives.
   function automatic pixel_type walk_step(pixel_req_type w);
      int        x0;
      int        y0;
      int        x1;
      int        y1;
      int        dx;
      int        dy;
      int        ax;
      int        ay;
      int        bx;
      int        by;
      pixel_type p;
      p = '0;
      if (w.func == FUNC_START) begin
         x0 = w.x0;
         y0 = w.y0;
         x1 = w.x1;
         y1 = w.y1;
         dx = x1 - x0;
         dy = y1 - y0;
         if ((dx < 0 ? -dx : dx) >= (dy < 0 ? -dy : dy)) begin
            if (dx >= 0 && dy >= 0) begin
               walk_zone = ZONE_E_NE; ax = x0;  ay = y0;  bx = x1;  by = y1;
            end else if (dx < 0 && dy >= 0) begin
               walk_zone = ZONE_NW_W; ax = -x0; ay = y0;  bx = -x1; by = y1;
            end else if (dx < 0) begin
               walk_zone = ZONE_W_SW; ax = -x0; ay = -y0; bx = -x1; by = -y1;
            end else begin
               walk_zone = ZONE_SE_E; ax = x0;  ay = -y0; bx = x1;  by = -y1;
            end
         end else begin
            if (dx >= 0 && dy >= 0) begin
               walk_zone = ZONE_NE_N; ax = y0;  ay = x0;  bx = y1;  by = x1;
            end else if (dx < 0 && dy >= 0) begin
               walk_zone = ZONE_N_NW; ax = y0;  ay = -x0; bx = y1;  by = -x1;
            end else if (dx < 0) begin
               walk_zone = ZONE_SW_S; ax = -y0; ay = -x0; bx = -y1; by = -x1;
            end else begin
               walk_zone = ZONE_S_SE; ax = -y0; ay = x0;  bx = -y1; by = x1;
            end
         end
         walk_x      = WALK_BITS'(ax);
         walk_y      = WALK_BITS'(ay);
         stop_x      = WALK_BITS'(bx);
         step_east   = DEC_BITS'(2 * (by - ay));
         step_diag   = DEC_BITS'(2 * ((by - ay) - (bx - ax)));
         decision    = DEC_BITS'(2 * (by - ay) - (bx - ax));
         walk_active = (walk_x != stop_x);
         return screen_pixel(!walk_active);
      end
      if (!walk_active) return p;
      if (decision < 0) begin
         decision = DEC_BITS'(decision + step_east);
      end else begin
         decision = DEC_BITS'(decision + step_diag);
         walk_y   = WALK_BITS'(walk_y + 1);
      end
      walk_x      = WALK_BITS'(walk_x + 1);
      walk_active = (walk_x != stop_x);
      return screen_pixel(!walk_active);
   endfunction

   function automatic int rand_coord();
      return int'($urandom_range(4095)) - 2048;
   endfunction

   // A coordinate within span of c, reflected back if it would leave the screen.
   function automatic int near_coord(int c, int span);
      int d;
      d = int'($urandom_range(2 * span)) - span;
      if (c + d > 2047 || c + d < -2048) return c - d;
      return c + d;
   endfunction

   function automatic pixel_req_type random_word(func_type f);
      pixel_req_type w;
      w.func = f;
      w.x0   = COORD_BITS'(rand_coord());
      w.y0   = COORD_BITS'(rand_coord());
      w.x1   = COORD_BITS'(rand_coord());
      w.y1   = COORD_BITS'(rand_coord());
      return w;
   endfunction

   task automatic add_row(func_type f, int x0, int y0, int x1, int y1, bit typed,
                          bit pv, int px, int py, zone_type z, bit lst);
      directed_row_type r;
      r.word.func        = f;
      r.word.x0          = COORD_BITS'(x0);
      r.word.y0          = COORD_BITS'(y0);
      r.word.x1          = COORD_BITS'(x1);
      r.word.y1          = COORD_BITS'(y1);
      r.typed            = typed;
      r.want.pixel_valid = pv;
      r.want.pixel_x     = COORD_BITS'(px);
      r.want.pixel_y     = COORD_BITS'(py);
      r.want.octant      = z;
      r.want.last        = lst;
      directed_rows.push_back(r);
   endtask

   task automatic send_word(pixel_req_type w, bit typed, pixel_type want);
      pixel_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_func    <= w.func;
      req_start_x <= w.x0;
      req_start_y <= w.y0;
      req_end_x   <= w.x1;
      req_end_y   <= w.y1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = walk_step(w);
      if (w.func == FUNC_START) lines_started++;
      else if (!predicted.pixel_valid) idle_advances++;
      pending_pixels.push_back(typed ? want : predicted);
      words_sent++;
   endtask

   task automatic run_phase(int send_pct, int recv_pct, bit with_backlog);
      int            goal;
      int            kind;
      int            span;
      int            extra;
      pixel_req_type w;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      if (with_backlog) backlog_ask <= backlog_ask + 1;
      goal = words_sent + PHASE_WORDS;
      while (words_sent < goal) begin
         kind = $urandom_range(99);
         if (kind < 70) begin
            // Complete line walked to its endpoint, mostly short.
            span = ($urandom_range(19) == 0) ? 120 : 12;
            w    = random_word(FUNC_START);
            w.x1 = COORD_BITS'(near_coord(w.x0, span));
            w.y1 = COORD_BITS'(near_coord(w.y0, span));
            send_word(w, 1'b0, '0);
            while (walk_active) send_word(random_word(FUNC_ADVANCE), 1'b0, '0);
            extra = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
            repeat (extra) send_word(random_word(FUNC_ADVANCE), 1'b0, '0);
         end else if (kind < 88) begin
            // Long line cut short by the next start.
            send_word(random_word(FUNC_START), 1'b0, '0);
            repeat ($urandom_range(12)) send_word(random_word(FUNC_ADVANCE), 1'b0, '0);
         end else begin
            send_word(random_word(func_type'($urandom_range(1))), 1'b0, '0);
         end
      end
   endtask

   // Receiver: random stalls, plus a long hold-off whenever one is asked for.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall    <= 1'b0;
         backlog_left <= 0;
      end else if (backlog_seen != backlog_ask) begin
         backlog_seen <= backlog_ask;
         backlog_left <= BACKLOG_HOLD;
         rsp_stall    <= 1'b1;
      end else if (backlog_left > 0) begin
         backlog_left <= backlog_left - 1;
         rsp_stall    <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   function automatic void field_check(string name, int want, int got);
      if (want != got) begin
         if (fault_count < REPORT_LIMIT)
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fault_count++;
      end
   endfunction

   always @(posedge clock) begin
      pixel_type want;
      if (!reset) begin
         if (req_valid && req_stall) held_off_cycles++;
         if (rsp_valid && !rsp_stall) begin
            if (pending_pixels.size() == 0) begin
               if (fault_count < REPORT_LIMIT)
                  $error("pixel word arrived with nothing expected");
               fault_count++;
            end else begin
               want = pending_pixels.pop_front();
               field_check("pixel_valid", want.pixel_valid, rsp_pixel_valid);
               field_check("pixel_x", want.pixel_x, rsp_pixel_x);
               field_check("pixel_y", want.pixel_y, rsp_pixel_y);
               field_check("octant", want.octant, rsp_octant);
               field_check("last", want.last, rsp_last);
               pixels_checked++;
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      // Advances with no line, zero-length lines at the corners, one line per zone,
      // and two full-diagonal lines between opposite corners.
      add_row(FUNC_ADVANCE, 0, 0, 0, 0, 1'b1, 1'b0, 0, 0, ZONE_E_NE, 1'b0);
      add_row(FUNC_START, 2047, -2048, 2047, -2048, 1'b1, 1'b1, 2047, -2048, ZONE_E_NE, 1'b1);
      add_row(FUNC_START, -2048, 2047, -2048, 2047, 1'b1, 1'b1, -2048, 2047, ZONE_E_NE, 1'b1);
      add_row(FUNC_ADVANCE, 0, 0, 0, 0, 1'b1, 1'b0, 0, 0, ZONE_E_NE, 1'b0);
      add_row(FUNC_START, 10, 20, 11, 21, 1'b1, 1'b1, 10, 20, ZONE_E_NE, 1'b0);
      add_row(FUNC_ADVANCE, 0, 0, 0, 0, 1'b0, 1'b0, 0, 0, ZONE_E_NE, 1'b0);
      add_row(FUNC_START, -30, 5, -30, 6, 1'b1, 1'b1, -30, 5, ZONE_NE_N, 1'b0);
      add_row(FUNC_ADVANCE, 0, 0, 0, 0, 1'b0, 1'b0, 0, 0, ZONE_E_NE, 1'b0);
      add_row(FUNC_START, 7, 7, 6, 9, 1'b1, 1'b1, 7, 7, ZONE_N_NW, 1'b0);
      add_row(FUNC_ADVANCE, 0, 0, 0, 0, 1'b0, 1'b0, 0, 0, ZONE_E_NE, 1'b0);
      // This start drops the zone 2 line before its endpoint.
      add_row(FUNC_START, 0, 0, -1, 0, 1'b1, 1'b1, 0, 0, ZONE_NW_W, 1'b0);
      add_row(FUNC_ADVANCE, 0, 0, 0, 0, 1'b0, 1'b0, 0, 0, ZONE_E_NE, 1'b0);
      add_row(FUNC_START, 100, -100, 99, -101, 1'b1, 1'b1, 100, -100, ZONE_W_SW, 1'b0);
      add_row(FUNC_ADVANCE, 0, 0, 0, 0, 1'b0, 1'b0, 0, 0, ZONE_E_NE, 1'b0);
      add_row(FUNC_START, -5, -5, -6, -7, 1'b1, 1'b1, -5, -5, ZONE_SW_S, 1'b0);
      add_row(FUNC_ADVANCE, 0, 0, 0, 0, 1'b0, 1'b0, 0, 0, ZONE_E_NE, 1'b0);
      add_row(FUNC_START, 3, -3, 3, -4, 1'b1, 1'b1, 3, -3, ZONE_S_SE, 1'b0);
      add_row(FUNC_ADVANCE, 0, 0, 0, 0, 1'b0, 1'b0, 0, 0, ZONE_E_NE, 1'b0);
      add_row(FUNC_START, -1, 1, 0, 0, 1'b1, 1'b1, -1, 1, ZONE_SE_E, 1'b0);
      add_row(FUNC_ADVANCE, 0, 0, 0, 0, 1'b0, 1'b0, 0, 0, ZONE_E_NE, 1'b0);
      add_row(FUNC_START, -2048, -2048, 2047, 2047, 1'b1, 1'b1, -2048, -2048, ZONE_E_NE, 1'b0);
      add_row(FUNC_ADVANCE, 0, 0, 0, 0, 1'b0, 1'b0, 0, 0, ZONE_E_NE, 1'b0);
      add_row(FUNC_START, 2047, -2048, -2048, 2047, 1'b1, 1'b1, 2047, -2048, ZONE_NW_W, 1'b0);
      add_row(FUNC_ADVANCE, 0, 0, 0, 0, 1'b0, 1'b0, 0, 0, ZONE_E_NE, 1'b0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 6;
      recv_idle_pct = 62;
      foreach (directed_rows[i])
         send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);

      run_phase(6, 62, 1'b1);
      run_phase(62, 6, 1'b0);
      run_phase(0, 0, 1'b1);

      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d request words: %0d line starts, %0d advances with no line in progress.",
               words_sent, lines_started, idle_advances);
      $display("Checked %0d pixel words; input held off for %0d cycles under back-pressure.",
               pixels_checked, held_off_cycles);
      if (fault_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
